// ----- rtl/btlv_pkg.sv -----
// Shared types and constants for the BER-TLV stream parser.
package btlv_pkg;

    // Nesting and length limits
    localparam int MAX_DEPTH       = 8;
    localparam int MAX_LEN_BYTES   = 3;
    localparam int STACK_SLOTS     = MAX_DEPTH + 1;
    localparam int STK_IDX_W       = $clog2(STACK_SLOTS);
    localparam int LEVEL_W         = $clog2(STACK_SLOTS + 1);
    localparam int LEFT_W          = $clog2(MAX_LEN_BYTES + 1);

    // Datapath widths
    localparam int POS_W           = 16;
    localparam int NEXT_W          = POS_W + 1;
    localparam int LEN_W           = 24;
    localparam int END_W           = LEN_W + 1;
    localparam int CLOSED_W        = 4;

    localparam logic [POS_W-1:0] POS_SAT   = '1;
    localparam logic [LEN_W-1:0] LEN_SAT   = '1;
    localparam logic [LEN_W-1:0] LEN_2BYTE = LEN_W'(16'hFFFF);

    // Tag and length byte fields
    localparam logic [4:0] TAG_NUM_MULTI = 5'h1F;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 1'b1;
    localparam logic [CFG_DATA_W-1:0] MAX_BYTES_RST = 16'd16384;

    // Byte role; also used as the header phase of the parser
    typedef enum logic [2:0] {
        ROLE_TAG_FIRST = 3'd0,
        ROLE_TAG_CONT  = 3'd1,
        ROLE_LEN_FIRST = 3'd2,
        ROLE_LEN_EXT   = 3'd3,
        ROLE_VALUE     = 3'd4
    } t_role;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_TAG_INCOMPLETE = 3'd1,
        ST_LEN_MISSING    = 3'd2,
        ST_LEN_FORMAT     = 3'd3,
        ST_LEN_EXCEEDS    = 3'd4,
        ST_TOO_DEEP       = 3'd5,
        ST_TOO_LARGE      = 3'd6,
        ST_TRAILING       = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_role               byte_role;
        logic [LEVEL_W-1:0]  level;
        logic                is_constructed;
        logic                header_done;
        logic [LEN_W-1:0]    value_length;
        logic [CLOSED_W-1:0] closed_count;
        logic                final_res;
        t_status             status;
    } t_out_item;

    typedef struct packed {
        logic                  list_mode;
        logic [CFG_DATA_W-1:0] max_response_bytes;
    } t_cfg;

endpackage

// ----- rtl/btlv_in_stage.sv -----
// Input register stage: holds one accepted byte until the parser takes it.
module btlv_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  btlv_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output btlv_pkg::t_in_item o_item
);
    import btlv_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    // Full and not drained this cycle: hold off the sender
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/btlv_parse.sv -----
// Parser state and the combinational decode of one byte.
module btlv_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btlv_pkg::t_cfg      i_cfg,
    input  btlv_pkg::t_in_item  i_item,
    input  logic                i_fire,
    output btlv_pkg::t_out_item o_result
);
    import btlv_pkg::*;

    // Parse state
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [END_W-1:0]   r_stack [STACK_SLOTS];
    logic [LEVEL_W-1:0] r_level, n_level;
    t_role              r_phase, n_phase;
    logic [LEN_W-1:0]   r_acc,   n_acc;
    logic [LEFT_W-1:0]  r_left,  n_left;
    logic               r_cons,  n_cons;
    t_status            r_err,   n_err;
    logic               r_root,  n_root;

    // Decode helpers
    logic [7:0]          b;
    logic [6:0]          cnt;
    logic [NEXT_W-1:0]   next_pos;
    logic [END_W-1:0]    next_ext;
    logic [END_W-1:0]    top_end;
    logic                room_inf;
    logic [END_W-1:0]    room;
    logic                room_zero;
    logic                cnt_bad;
    logic [LEN_W-1:0]    acc_ext;
    logic [LEFT_W-1:0]   left_dec;
    logic                done;
    logic                push;
    logic [END_W-1:0]    new_end;
    logic [END_W-1:0]    entry;
    logic [END_W-1:0]    stack0;
    logic                keep;
    logic [CLOSED_W-1:0] closed;
    logic                too_large;
    logic                outer_exc;
    t_out_item           res;

    assign b        = i_item.data_byte;
    assign cnt      = b[6:0];
    assign next_pos = NEXT_W'(r_pos) + NEXT_W'(1);
    assign next_ext = END_W'(next_pos);

    // Room left in the innermost open element
    assign room_inf  = (r_level == '0);
    assign top_end   = room_inf ? '0 : r_stack[STK_IDX_W'(r_level - LEVEL_W'(1))];
    assign room      = (top_end > next_ext) ? (top_end - next_ext) : '0;
    assign room_zero = !room_inf && (room == '0);
    assign cnt_bad   = (cnt == '0) || (cnt > 7'(MAX_LEN_BYTES)) ||
                       (!room_inf && (END_W'(cnt) > room));

    // Long-form length accumulation with saturation
    assign acc_ext  = (r_acc > LEN_2BYTE) ? LEN_SAT : {r_acc[LEN_W-9:0], b};
    assign left_dec = (r_left != '0) ? (r_left - LEFT_W'(1)) : '0;

    // Byte decode, stack push and element closing
    always_comb begin
        n_pos   = (r_pos != POS_SAT) ? (r_pos + POS_W'(1)) : r_pos;
        n_level = r_level;
        n_phase = r_phase;
        n_acc   = r_acc;
        n_left  = r_left;
        n_cons  = r_cons;
        n_err   = r_err;
        n_root  = r_root;
        done    = 1'b0;
        push    = 1'b0;
        closed  = '0;
        keep    = 1'b1;
        entry   = '0;
        new_end = '0;

        res                = '0;
        res.byte_role      = ROLE_VALUE;
        res.status         = ST_OK;
        res.final_res      = i_item.last_byte;

        if (r_err == ST_OK && !i_cfg.list_mode && r_root) begin
            // Data after a complete single root
            n_err = ST_TRAILING;
        end else if (r_err == ST_OK) begin
            res.byte_role = r_phase;
            res.level     = (r_phase == ROLE_VALUE && r_level != '0) ?
                            (r_level - LEVEL_W'(1)) : r_level;

            unique case (r_phase)
                ROLE_TAG_FIRST: begin
                    if (r_level > LEVEL_W'(MAX_DEPTH)) begin
                        n_err = ST_TOO_DEEP;
                    end else begin
                        n_cons = b[5];
                        n_acc  = '0;
                        n_left = '0;
                        if (b[4:0] == TAG_NUM_MULTI) begin
                            if (room_zero) n_err = ST_TAG_INCOMPLETE;
                            else n_phase = ROLE_TAG_CONT;
                        end else begin
                            if (room_zero) n_err = ST_LEN_MISSING;
                            else n_phase = ROLE_LEN_FIRST;
                        end
                    end
                end
                ROLE_TAG_CONT: begin
                    if (!b[7]) begin
                        if (room_zero) n_err = ST_LEN_MISSING;
                        else n_phase = ROLE_LEN_FIRST;
                    end else if (room_zero) begin
                        n_err = ST_TAG_INCOMPLETE;
                    end
                end
                ROLE_LEN_FIRST: begin
                    if (!b[7]) begin
                        n_acc = LEN_W'(b);
                        done  = 1'b1;
                    end else if (cnt_bad) begin
                        n_err = ST_LEN_FORMAT;
                    end else begin
                        n_left  = cnt[LEFT_W-1:0];
                        n_acc   = '0;
                        n_phase = ROLE_LEN_EXT;
                    end
                end
                ROLE_LEN_EXT: begin
                    n_acc  = acc_ext;
                    n_left = left_dec;
                    done   = (left_dec == '0);
                end
                default: begin
                end
            endcase

            res.is_constructed = n_cons;

            // Length complete: check against parent, then open the element
            if (done) begin
                res.header_done  = 1'b1;
                res.value_length = n_acc;
                new_end          = next_ext + END_W'(n_acc);
                if (!room_inf && (END_W'(n_acc) > room)) begin
                    n_err = ST_LEN_EXCEEDS;
                end else if (r_level < LEVEL_W'(STACK_SLOTS)) begin
                    push    = 1'b1;
                    n_level = r_level + LEVEL_W'(1);
                    n_phase = n_cons ? ROLE_TAG_FIRST : ROLE_VALUE;
                end else begin
                    n_err = ST_TOO_DEEP;
                end
            end

            // Pop every open element that ends at this byte, innermost first
            if (n_err == ST_OK) begin
                for (int i = STACK_SLOTS - 1; i >= 0; i--) begin
                    entry = (push && LEVEL_W'(i) == r_level) ? new_end : r_stack[i];
                    if (LEVEL_W'(i) < n_level) begin
                        if (keep && entry == next_ext) closed = closed + CLOSED_W'(1);
                        else keep = 1'b0;
                    end
                end
                res.closed_count = closed;
                if (closed != '0) begin
                    n_level = n_level - LEVEL_W'(closed);
                    n_phase = ROLE_TAG_FIRST;
                    if (n_level == (LEVEL_W'(closed) - LEVEL_W'(closed))) n_root = 1'b1;
                end
            end
        end

        // Final byte: overall status, then back to the start of a response
        stack0    = (push && r_level == '0) ? new_end : r_stack[0];
        too_large = (n_pos > i_cfg.max_response_bytes) || (n_pos == POS_SAT);
        outer_exc = (n_level != '0) && (stack0 > END_W'(n_pos));
        if (i_item.last_byte) begin
            if (too_large) begin
                res.status = ST_TOO_LARGE;
            end else if (outer_exc) begin
                res.status = ST_LEN_EXCEEDS;
            end else if (n_err != ST_OK) begin
                res.status = n_err;
            end else begin
                case (n_phase)
                    ROLE_TAG_CONT:  res.status = ST_TAG_INCOMPLETE;
                    ROLE_LEN_FIRST: res.status = ST_LEN_MISSING;
                    ROLE_LEN_EXT:   res.status = ST_LEN_FORMAT;
                    default:        res.status = ST_OK;
                endcase
            end
            n_pos   = '0;
            n_level = '0;
            n_phase = ROLE_TAG_FIRST;
            n_acc   = '0;
            n_left  = '0;
            n_cons  = 1'b0;
            n_err   = ST_OK;
            n_root  = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_level <= '0;
            r_phase <= ROLE_TAG_FIRST;
            r_acc   <= '0;
            r_left  <= '0;
            r_cons  <= 1'b0;
            r_err   <= ST_OK;
            r_root  <= 1'b0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_level <= n_level;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_cons  <= n_cons;
            r_err   <= n_err;
            r_root  <= n_root;
        end
    end

    // End offset stack; entries at or above the level are never read
    always_ff @(posedge i_clk) begin
        if (i_fire && push) begin
            r_stack[r_level[STK_IDX_W-1:0]] <= new_end;
        end
    end

    assign o_result = res;

endmodule

// ----- rtl/btlv_out_stage.sv -----
// Result register stage with the downstream valid/stall handshake.
module btlv_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  btlv_pkg::t_out_item i_item,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_stall,
    output btlv_pkg::t_out_item o_item
);
    import btlv_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    // Empty, or the held item leaves this cycle
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/ber_tlv_stream_parser.sv -----
// BER-TLV stream parser top level: configuration registers and the two-stage byte path.
// Takes one response byte per cycle unless the receiver stalls and returns one labelled
// result item per byte, via the input register, then the result register. Each byte is
// decoded combinationally against the innermost open element's end offset, and all nine
// stack entries are compared in parallel to count the elements that close on that byte, so
// a byte may follow in every unstalled cycle. Status is meaningful on the final_res item;
// then a new response starts. The user must write list_mode and max_response_bytes
// through the configuration port only while no byte is in flight; this is not enforced.
module ber_tlv_stream_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  btlv_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output btlv_pkg::t_out_item                   o_out_item,
    input  logic                                  i_cfg_we,
    input  logic [btlv_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [btlv_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import btlv_pkg::*;

    t_cfg      r_cfg;
    logic      in_valid;
    t_in_item  in_item;
    logic      out_free;
    logic      fire;
    t_out_item result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.list_mode          <= 1'b0;
            r_cfg.max_response_bytes <= MAX_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIST_MODE: r_cfg.list_mode          <= i_cfg_data[0];
                CFG_MAX_BYTES: r_cfg.max_response_bytes <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Byte moves from input register to result register
    assign fire = in_valid && out_free;

    btlv_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    btlv_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (in_item),
        .i_fire   (fire),
        .o_result (result)
    );

    btlv_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_item  (result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

// ----- rtl/btlv_checker.sv -----
// Port-level checks for the BER-TLV stream parser and their bind to the top level.
module btlv_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  btlv_pkg::t_in_item  i_in_item,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  btlv_pkg::t_out_item o_out_item
);
    import btlv_pkg::*;

    // A stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_item)))
        else $error("input item changed while stalled");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item changed while stalled");

    // Status only on the final byte of a response
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.final_res) |-> (o_out_item.status == ST_OK))
        else $error("status reported on a non-final byte");

    // Decoded length only where the length field completes
    a_len_hd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.header_done) |-> (o_out_item.value_length == '0))
        else $error("value length without header_done");

    // Elements close only on a length or value byte
    a_close_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.closed_count != '0) |->
        (o_out_item.byte_role == ROLE_LEN_FIRST || o_out_item.byte_role == ROLE_LEN_EXT ||
         o_out_item.byte_role == ROLE_VALUE))
        else $error("element closed on a tag byte");

endmodule

bind ber_tlv_stream_parser btlv_checker u_btlv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- verif/tlv_label_checker.sv -----
// Checker for the BER-TLV stream parser: predicts the label of each byte and compares results.
`timescale 1ns / 1ps
module tlv_label_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  btlv_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  btlv_pkg::t_out_item             i_out_item,
    input  logic                            i_cfg_we,
    input  logic [btlv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [btlv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import btlv_pkg::*;

    // Shadow copy of the configuration registers
    logic                  list_mode;
    logic [CFG_DATA_W-1:0] max_bytes;

    // Parser state of the prediction
    logic [POS_W-1:0]  byte_count;
    logic [END_W-1:0]  end_stack [STACK_SLOTS];
    int unsigned       depth;
    t_role             phase;
    logic [LEN_W-1:0]  len_acc;
    logic [LEFT_W-1:0] len_left;
    logic              cons_flag;
    t_status           err;
    logic              root_done;

    t_out_item expected_labels [$];

    // Back to the start of a response; registers are kept
    function automatic void restart_response();
        byte_count = '0;
        foreach (end_stack[k]) end_stack[k] = '0;
        depth      = 0;
        phase      = ROLE_TAG_FIRST;
        len_acc    = '0;
        len_left   = '0;
        cons_flag  = 1'b0;
        err        = ST_OK;
        root_done  = 1'b0;
    endfunction

    // Label one byte and advance the parse state
    task automatic label_byte(input t_in_item item, output t_out_item res);
        logic [7:0]  b;
        int unsigned nxt;
        int unsigned room;
        int unsigned closed;
        int unsigned total;
        logic        done;
        b      = item.data_byte;
        nxt    = 32'(byte_count) + 1;
        closed = 0;
        done   = 1'b0;
        res    = '0;
        res.byte_role = ROLE_VALUE;
        res.status    = ST_OK;
        if (byte_count != POS_SAT) byte_count++;

        if (err == ST_OK && !list_mode && root_done) begin
            // single root already closed: anything more is trailing data
            err = ST_TRAILING;
        end else if (err == ST_OK) begin
            // room left in the innermost open element
            room = 32'hFFFF_FFFF;
            if (depth > 0)
                room = (end_stack[depth-1] > nxt) ? end_stack[depth-1] - nxt : 0;
            res.byte_role = phase;
            res.level = LEVEL_W'((phase == ROLE_VALUE && depth > 0) ? depth - 1 : depth);

            case (phase)
                ROLE_TAG_FIRST: begin
                    if (depth > MAX_DEPTH) begin
                        err = ST_TOO_DEEP;
                    end else begin
                        cons_flag = b[5];
                        len_acc   = '0;
                        len_left  = '0;
                        if (b[4:0] == TAG_NUM_MULTI) begin
                            if (room == 0) err = ST_TAG_INCOMPLETE;
                            else phase = ROLE_TAG_CONT;
                        end else if (room == 0) begin
                            err = ST_LEN_MISSING;
                        end else begin
                            phase = ROLE_LEN_FIRST;
                        end
                    end
                end
                ROLE_TAG_CONT: begin
                    if (!b[7]) begin
                        if (room == 0) err = ST_LEN_MISSING;
                        else phase = ROLE_LEN_FIRST;
                    end else if (room == 0) begin
                        err = ST_TAG_INCOMPLETE;
                    end
                end
                ROLE_LEN_FIRST: begin
                    if (!b[7]) begin
                        len_acc = LEN_W'(b);
                        done    = 1'b1;
                    end else if (b[6:0] == 0 || b[6:0] > MAX_LEN_BYTES || b[6:0] > room) begin
                        err = ST_LEN_FORMAT;
                    end else begin
                        len_left = LEFT_W'(b[6:0]);
                        len_acc  = '0;
                        phase    = ROLE_LEN_EXT;
                    end
                end
                ROLE_LEN_EXT: begin
                    // big-endian length bytes, saturating past 24 bits
                    len_acc = (len_acc > LEN_2BYTE) ? LEN_SAT : {len_acc[15:0], b};
                    if (len_left != 0) len_left--;
                    if (len_left == 0) done = 1'b1;
                end
                default: ;
            endcase
            res.is_constructed = cons_flag;

            // header complete: bound check against the parent, then open the element
            if (done) begin
                res.header_done  = 1'b1;
                res.value_length = len_acc;
                if (len_acc > room) begin
                    err = ST_LEN_EXCEEDS;
                end else if (depth < STACK_SLOTS) begin
                    end_stack[depth] = END_W'(nxt + len_acc);
                    depth++;
                    if (cons_flag) phase = ROLE_TAG_FIRST;
                    else phase = ROLE_VALUE;
                end else begin
                    err = ST_TOO_DEEP;
                end
            end

            // pop every element that ends on this byte
            if (err == ST_OK) begin
                while (depth > 0 && end_stack[depth-1] == nxt) begin
                    depth--;
                    closed++;
                end
                if (closed > 0) begin
                    phase = ROLE_TAG_FIRST;
                    if (depth == 0) root_done = 1'b1;
                end
            end
            res.closed_count = CLOSED_W'(closed);
        end

        // status of the whole response on its last byte
        if (item.last_byte) begin
            total = byte_count;
            if (total > max_bytes || total >= POS_SAT) res.status = ST_TOO_LARGE;
            else if (depth > 0 && end_stack[0] > total) res.status = ST_LEN_EXCEEDS;
            else if (err != ST_OK) res.status = err;
            else if (phase == ROLE_TAG_CONT) res.status = ST_TAG_INCOMPLETE;
            else if (phase == ROLE_LEN_FIRST) res.status = ST_LEN_MISSING;
            else if (phase == ROLE_LEN_EXT) res.status = ST_LEN_FORMAT;
            restart_response();
        end
        res.final_res = item.last_byte;
    endtask

    function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Config shadow, result compare, then prediction of the accepted byte
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            list_mode = 1'b0;
            max_bytes = MAX_BYTES_RST;
            restart_response();
            expected_labels.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LIST_MODE) list_mode = i_cfg_data[0];
                else if (i_cfg_idx == CFG_MAX_BYTES) max_bytes = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_labels.size() == 0) begin
                    $error("result item with no byte waiting for it");
                    o_fail_count++;
                end else begin
                    want = expected_labels.pop_front();
                    got  = i_out_item;
                    o_fail_count += field_bad("byte_role", want.byte_role, got.byte_role);
                    o_fail_count += field_bad("level", want.level, got.level);
                    o_fail_count += field_bad("is_constructed", want.is_constructed,
                                              got.is_constructed);
                    o_fail_count += field_bad("header_done", want.header_done,
                                              got.header_done);
                    o_fail_count += field_bad("value_length", want.value_length,
                                              got.value_length);
                    o_fail_count += field_bad("closed_count", want.closed_count,
                                              got.closed_count);
                    o_fail_count += field_bad("final_res", want.final_res, got.final_res);
                    o_fail_count += field_bad("status", want.status, got.status);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                label_byte(i_in_item, want);
                expected_labels.insert(expected_labels.size(), want);
            end
        end
        o_pending = expected_labels.size();
    end

endmodule

// ----- verif/tb_ber_tlv_stream_parser.sv -----
// Testbench top for the BER-TLV stream parser: response stimulus, flow pacing and verdict.
`timescale 1ns / 1ps
module tb_ber_tlv_stream_parser;
    import btlv_pkg::*;

    typedef logic [7:0] t_byte_list [$];

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_LIST_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    bit                    quiet    = 1'b0;
    int                    rx_wait  = 0;

    always #6 clk = ~clk;

    ber_tlv_stream_parser DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tlv_label_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver: after each result item, stall at random unless the bench is quiet
    always @(posedge clk) begin
        if (out_valid && !out_stall) rx_wait = quiet ? 0 : $urandom_range(0, 3);
    end

    always @(negedge clk) begin
        if (rx_wait > 0) begin
            out_stall <= 1'b1;
            rx_wait = rx_wait - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic void append(ref t_byte_list dst, input t_byte_list src);
        foreach (src[k]) dst.insert(dst.size(), src[k]);
    endfunction

    // Length field: short form, or long form with possible leading zero bytes
    function automatic t_byte_list length_field(int unsigned len);
        t_byte_list r;
        int         nb;
        if (len < 128 && $urandom_range(0, 3) != 0) begin
            r.insert(r.size(), 8'(len));
        end else begin
            if (len > 16'hFFFF) nb = 3;
            else if (len > 8'hFF) nb = $urandom_range(2, 3);
            else nb = $urandom_range(1, MAX_LEN_BYTES);
            r.insert(r.size(), 8'h80 | 8'(nb));
            for (int k = nb - 1; k >= 0; k--) r.insert(r.size(), 8'(len >> (8 * k)));
        end
        return r;
    endfunction

    // Tag field: one byte, or a multi-byte tag with 0..2 continuation bytes
    function automatic t_byte_list tag_field(logic constructed);
        t_byte_list r;
        logic [7:0] t;
        t    = 8'($urandom);
        t[5] = constructed;
        if ($urandom_range(0, 3) == 0) begin
            t[4:0] = TAG_NUM_MULTI;
            r.insert(r.size(), t);
            repeat ($urandom_range(0, 2))
                r.insert(r.size(), 8'h80 | 8'($urandom_range(0, 127)));
            r.insert(r.size(), 8'($urandom_range(0, 127)));
        end else begin
            if (t[4:0] == TAG_NUM_MULTI) t[4:0] = 5'h1E;
            r.insert(r.size(), t);
        end
        return r;
    endfunction

    // Well-formed element; nesting gets rarer deeper down
    function automatic t_byte_list make_element(int unsigned lvl);
        t_byte_list body;
        t_byte_list r;
        logic       cons;
        int         n;
        cons = (lvl <= MAX_DEPTH) && ($urandom_range(0, lvl + 1) == 0);
        if (cons) begin
            repeat ($urandom_range(0, 3)) append(body, make_element(lvl + 1));
        end else begin
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 260) : $urandom_range(0, 6);
            repeat (n) body.insert(body.size(), 8'($urandom));
        end
        r = tag_field(cons);
        append(r, length_field(body.size()));
        append(r, body);
        return r;
    endfunction

    // Straight chain of constructed elements around one primitive
    function automatic t_byte_list make_chain(int levels);
        t_byte_list body;
        t_byte_list r;
        body = make_element(MAX_DEPTH + 1);
        repeat (levels) begin
            r = tag_field(1'b1);
            append(r, length_field(body.size()));
            append(r, body);
            body = r;
        end
        return body;
    endfunction

    // Mostly well-formed responses; the rest truncated, corrupted, noise or padded
    function automatic t_byte_list make_response(logic lst);
        t_byte_list r;
        int         kind;
        kind = $urandom_range(0, 11);
        if (kind == 6) begin
            append(r, make_chain($urandom_range(MAX_DEPTH - 1, MAX_DEPTH + 1)));
        end else if (kind == 9) begin
            repeat ($urandom_range(1, 8)) r.insert(r.size(), 8'($urandom));
        end else begin
            repeat (lst ? $urandom_range(1, 3) : 1) append(r, make_element(0));
        end
        if (kind == 7 && r.size() > 1) begin
            repeat ($urandom_range(1, r.size() - 1)) void'(r.pop_back());
        end
        if (kind == 8) r[$urandom_range(0, r.size() - 1)] = 8'($urandom);
        if (kind == 10) repeat ($urandom_range(1, 3)) r.insert(r.size(), 8'($urandom));
        return r;
    endfunction

    // Sender: random gap, then hold the item until it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {b, last};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_config(input logic lst, input logic [CFG_DATA_W-1:0] cap);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LIST_MODE;
        cfg_data <= CFG_DATA_W'(lst);
        @(negedge clk);
        cfg_idx  <= CFG_MAX_BYTES;
        cfg_data <= cap;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Send one response; now and then hold off until the block has drained
    task automatic send_response(input t_byte_list q);
        int hold_at;
        hold_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, q.size() - 1) : -1;
        foreach (q[k]) begin
            if (k == hold_at) wait_results();
            send_byte(q[k], k == q.size() - 1);
        end
    endtask

    initial begin
        t_byte_list            resp;
        int                    sent;
        logic                  lst;
        logic [CFG_DATA_W-1:0] cap;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_config(1'b0, MAX_BYTES_RST);

        // nested pair under a three-byte constructed tag, both close on the last byte
        resp = {8'h7F, 8'h81, 8'h01, 8'h03, 8'h80, 8'h01, 8'hFF};
        send_response(resp);
        // tag cut short
        resp = {8'h1F};
        send_response(resp);
        // length never arrives
        resp = {8'h04};
        send_response(resp);
        // too many length bytes, then a byte after the parser has halted
        resp = {8'h04, 8'h85, 8'h12};
        send_response(resp);
        // top-level length beyond the response
        resp = {8'h04, 8'h83, 8'hFF, 8'hFF, 8'hFF};
        send_response(resp);
        // data after the single root
        resp = {8'h04, 8'h00, 8'h00};
        send_response(resp);

        // smallest size limit: one byte fits, two do not
        wait_results();
        write_config(1'b1, 16'd1);
        resp = {8'h00};
        send_response(resp);
        resp = {8'h04, 8'h00};
        send_response(resp);

        // random phases over both modes and a spread of size limits
        for (int p = 0; p < 8; p++) begin
            wait_results();
            lst = p[0];
            case (p)
                0, 6:    cap = 16'd32768;
                1:       cap = 16'd1;
                2, 5:    cap = CFG_DATA_W'($urandom_range(2, 40));
                3:       cap = MAX_BYTES_RST;
                default: cap = CFG_DATA_W'($urandom_range(1, 32768));
            endcase
            quiet = (p == 3);
            write_config(lst, cap);
            sent = 0;
            while (sent < 60) begin
                resp = make_response(lst);
                send_response(resp);
                sent += resp.size();
            end
        end

        quiet = 1'b0;
        wait_results();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
